/* design/csf_pkg.sv */
package csf_pkg;

   localparam int CSF_DEPTH     = 32;
   localparam int CSF_TAG_WIDTH = 16;

   localparam int TAG_FIELD_W = 16;
   localparam int STATUS_W    = 3;
   localparam int FILL_W      = 6;
   localparam int WANTED_W    = 2;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WANTED_W-1:0] wanted_type;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic CLS_DOG = 1'b0;
   localparam logic CLS_CAT = 1'b1;

   localparam wanted_type WANT_ANY = 2'd0;
   localparam wanted_type WANT_DOG = 2'd1;
   localparam wanted_type WANT_CAT = 2'd2;

   localparam status_type ST_ADDED   = 3'd0;
   localparam status_type ST_REMOVED = 3'd1;
   localparam status_type ST_EMPTY   = 3'd2;
   localparam status_type ST_NOMATCH = 3'd3;
   localparam status_type ST_FULL    = 3'd4;

   // any-class request, and the unused code, match every entry
   function automatic logic class_match(wanted_type wanted, logic cls);
      logic hit;
      case (wanted)
         WANT_DOG: hit = (cls == CLS_DOG);
         WANT_CAT: hit = (cls == CLS_CAT);
         default:  hit = 1'b1;
      endcase
      return hit;
   endfunction

endpackage

/* design/csf_if.sv */
interface csf_req_if
   import csf_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic                   entry_class;
   logic [TAG_FIELD_W-1:0] entry_tag;
   wanted_type             wanted;

   modport source (output valid, output op, output entry_class, output entry_tag,
                   output wanted, input ready);
   modport sink   (input valid, input op, input entry_class, input entry_tag,
                   input wanted, output ready);
endinterface

interface csf_rsp_if
   import csf_pkg::*;
();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [TAG_FIELD_W-1:0] out_tag;
   logic                   out_class;
   logic [FILL_W-1:0]      fill;

   modport source (output valid, output status, output out_tag, output out_class,
                   output fill, input ready);
   modport sink   (input valid, input status, input out_tag, input out_class,
                   input fill, output ready);
endinterface

/* design/class_selective_fifo.sv */
// Ordered store of class-tagged words with class-selective removal.
// req_bus carries one request word: op selects append (tag and class go to the
// tail) or remove (the oldest entry of any class, the oldest dog, or the
// oldest cat leaves and later entries close the gap in order).
// rsp_bus returns exactly one result word per request: status, removed tag and
// class (zero unless removed) and the fill level after the request.
// Sequence, with the entry memory read through an output register:
//   append, empty remove, full append: straight from accept to finish.
//   remove with n entries held: a hit or no match takes equally long;
//   a hit at position h scans h + 1 entries, one per cycle, then closes
//   the gap one slot per cycle for the n - h - 1 later entries.
// One request is in flight at a time; req_bus.ready is high only when idle.
// Ready rises together with rsp valid, so the next request can be
// accepted while that result still waits on rsp_bus.
// The result sits in an output register: if rsp_bus stalls, the block holds
// the next result internally and waits for the register to free up.
// Reset (synchronous) empties the store and drops any pending result; the
// entry memory is not cleared, slots above the fill level are never used.
module class_selective_fifo
   import csf_pkg::*;
#(
   parameter int DEPTH     = CSF_DEPTH,
   parameter int TAG_WIDTH = CSF_TAG_WIDTH
) (
   input logic      clock,
   input logic      reset,
   csf_req_if.sink  req_bus,
   csf_rsp_if.source rsp_bus
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int STORE_W = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
   localparam int ENTRY_W = STORE_W + 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [1:0]         state_ff,   state_in;
   logic [CNT_W-1:0]   count_ff,   count_in;
   logic [IDX_W-1:0]   idx_ff,     idx_in;
   wanted_type         wanted_ff,  wanted_in;
   status_type         res_st_ff,  res_st_in;
   logic [STORE_W-1:0] res_tag_ff, res_tag_in;
   logic               res_cls_ff, res_cls_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_st_ff,    rsp_st_in;
   logic [TAG_FIELD_W-1:0] rsp_tag_ff,   rsp_tag_in;
   logic                   rsp_cls_ff,   rsp_cls_in;
   logic [FILL_W-1:0]      rsp_fill_ff,  rsp_fill_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic [IDX_W-1:0]   rd_addr;

   logic               accept;
   logic [CNT_W:0]     idx_p1;
   logic [CNT_W:0]     idx_p2;
   logic [CNT_W:0]     count_ext;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign idx_p1    = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(1);
   assign idx_p2    = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);
   assign count_ext = (CNT_W + 1)'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wanted_in    = wanted_ff;
      res_st_in    = res_st_ff;
      res_tag_in   = res_tag_ff;
      res_cls_in   = res_cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_fill_in  = rsp_fill_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[IDX_W-1:0];
      mem_wd       = {req_bus.entry_class, req_bus.entry_tag[STORE_W-1:0]};
      rd_addr      = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_tag_in = '0;
               res_cls_in = 1'b0;
               wanted_in  = req_bus.wanted;
               idx_in     = '0;
               rd_addr    = '0;
               state_in   = S_FINISH;
               if (req_bus.op == OP_APPEND) begin
                  if (count_ext >= (CNT_W + 1)'(DEPTH)) begin
                     res_st_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     res_st_in = ST_ADDED;
                  end
               end else if (count_ff == '0) begin
                  res_st_in = ST_EMPTY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (class_match(wanted_ff, rd_data_ff[STORE_W])) begin
               res_st_in  = ST_REMOVED;
               res_tag_in = rd_data_ff[STORE_W-1:0];
               res_cls_in = rd_data_ff[STORE_W];
               if (idx_p1 < count_ext) begin
                  // fetch the follower; the hit slot is overwritten next
                  rd_addr  = IDX_W'(idx_p1);
                  state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_FINISH;
               end
            end else if (idx_p1 < count_ext) begin
               rd_addr  = IDX_W'(idx_p1);
               idx_in   = IDX_W'(idx_p1);
            end else begin
               res_st_in = ST_NOMATCH;
               state_in  = S_FINISH;
            end
         end
         S_SHIFT: begin
            // move the follower down one slot
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = rd_data_ff;
            idx_in = IDX_W'(idx_p1);
            if (idx_p2 < count_ext) begin
               rd_addr = IDX_W'(idx_p2);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_tag_in   = TAG_FIELD_W'(res_tag_ff);
               rsp_cls_in   = res_cls_ff;
               rsp_fill_in  = FILL_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      wanted_ff   <= wanted_in;
      res_st_ff   <= res_st_in;
      res_tag_ff  <= res_tag_in;
      res_cls_ff  <= res_cls_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_st_ff;
   assign rsp_bus.out_tag   = rsp_tag_ff;
   assign rsp_bus.out_class = rsp_cls_ff;
   assign rsp_bus.fill      = rsp_fill_ff;

endmodule

/* design/csf_checker.sv */
module csf_checker
   import csf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input status_type             rsp_status,
   input logic [TAG_FIELD_W-1:0] rsp_out_tag,
   input logic                   rsp_out_class,
   input logic [FILL_W-1:0]      rsp_fill
);

   // a stalled result word holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_tag) && $stable(rsp_fill))
      else $error("stalled rsp word changed");

   // one request at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready stayed high after accept");

   // only a removal carries an entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REMOVED |-> rsp_out_tag == '0 && !rsp_out_class)
      else $error("entry data on a non-removal result");

   // an append leaves at least one entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ADDED |-> rsp_fill != '0)
      else $error("added result with zero fill");

endmodule

bind class_selective_fifo csf_checker u_csf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_out_tag   (rsp_bus.out_tag),
   .rsp_out_class (rsp_bus.out_class),
   .rsp_fill      (rsp_bus.fill)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import csf_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_ITEMS  = 680;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * CSF_DEPTH + 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int SLOT_W        = $clog2(CSF_DEPTH);

   // code 2'd3 has no meaning of its own; it must behave as an any-class remove
   localparam wanted_type WANT_UNUSED = 2'd3;

   typedef struct packed {
      logic                   op;
      logic                   cls;
      logic [TAG_FIELD_W-1:0] tag;
      wanted_type             wanted;
   } request_word_type;

   typedef struct packed {
      status_type             status;
      logic [TAG_FIELD_W-1:0] tag;
      logic                   cls;
      logic [FILL_W-1:0]      fill;
   } result_word_type;

   // Tracks the store contents and the results each request must produce.
   class entry_store_check;
      logic [TAG_FIELD_W-1:0] held_tag [CSF_DEPTH];
      logic                   held_class [CSF_DEPTH];
      int                     held_count;
      result_word_type        due_results [$];
      int                     mismatches;
      int                     status_hits [5];
      int                     peak_fill;

      function new();
         held_count = 0;
         mismatches = 0;
         peak_fill  = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function void note_request(request_word_type w);
         result_word_type r;
         int              hit;
         int              i;
         logic            match;
         r   = '0;
         hit = -1;
         if (w.op == OP_APPEND) begin
            if (held_count >= CSF_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_tag[SLOT_W'(held_count)] =
                  w.tag & TAG_FIELD_W'((64'd1 << CSF_TAG_WIDTH) - 1);
               held_class[SLOT_W'(held_count)] = w.cls;
               held_count++;
               r.status = ST_ADDED;
            end
         end else if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            for (i = 0; i < held_count && hit < 0; i++) begin
               case (w.wanted)
                  WANT_DOG: match = (held_class[SLOT_W'(i)] == CLS_DOG);
                  WANT_CAT: match = (held_class[SLOT_W'(i)] == CLS_CAT);
                  default:  match = 1'b1;
               endcase
               if (match) hit = i;
            end
            if (hit < 0) begin
               r.status = ST_NOMATCH;
            end else begin
               r.status = ST_REMOVED;
               r.tag    = held_tag[SLOT_W'(hit)];
               r.cls    = held_class[SLOT_W'(hit)];
               // close the gap, keep order
               for (i = hit; i + 1 < held_count; i++) begin
                  held_tag[SLOT_W'(i)]   = held_tag[SLOT_W'(i + 1)];
                  held_class[SLOT_W'(i)] = held_class[SLOT_W'(i + 1)];
               end
               held_count--;
            end
         end
         r.fill = FILL_W'(held_count);
         if (held_count > peak_fill) peak_fill = held_count;
         status_hits[r.status]++;
         due_results.push_back(r);
      endfunction

      function void flag(string field, logic [31:0] want_v, logic [31:0] got_v);
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      endfunction

      function void check_result(result_word_type got);
         result_word_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual status %0d tag %h",
                     $time, got.status, got.tag);
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status)
            flag("status", 32'(want.status), 32'(got.status));
         if (got.tag !== want.tag)
            flag("out_tag", 32'(want.tag), 32'(got.tag));
         if (got.cls !== want.cls)
            flag("out_class", 32'(want.cls), 32'(got.cls));
         if (got.fill !== want.fill)
            flag("fill", 32'(want.fill), 32'(got.fill));
      endfunction
   endclass

   logic clock;
   logic reset;

   csf_req_if req_bus ();
   csf_rsp_if rsp_bus ();

   class_selective_fifo DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   entry_store_check store = new();

   int   sent;
   int   received;
   int   idle_cycles;
   int   holds_done;
   bit   hold_off_req;
   bit   tx_calm;
   bit   rx_calm;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TAG_FIELD_W-1:0] random_tag();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return TAG_FIELD_W'($urandom);
      endcase
   endfunction

   function automatic request_word_type append_word(logic cls, logic [TAG_FIELD_W-1:0] tag);
      request_word_type w;
      w.op     = OP_APPEND;
      w.cls    = cls;
      w.tag    = tag;
      w.wanted = wanted_type'($urandom_range(3));
      return w;
   endfunction

   function automatic request_word_type remove_word(wanted_type wanted);
      request_word_type w;
      w.op     = OP_REMOVE;
      w.cls    = 1'($urandom_range(1));
      w.tag    = TAG_FIELD_W'($urandom);
      w.wanted = wanted;
      return w;
   endfunction

   // hold valid high into the next call unless a gap follows
   task automatic send_word(request_word_type w);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= w.op;
      req_bus.entry_class <= w.cls;
      req_bus.entry_tag   <= w.tag;
      req_bus.wanted      <= w.wanted;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      store.note_request(w);
      sent++;
   endtask

   task automatic send_and_gap(request_word_type w);
      int gap;
      send_word(w);
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (store.due_results.size() != 0);
   endtask

   task automatic mixed_run(int n);
      int k;
      int append_pct;
      for (k = 0; k < n; k++) begin
         append_pct = (store.held_count >= CSF_DEPTH - 2) ? 25 : 55;
         if ($urandom_range(99) < append_pct)
            send_and_gap(append_word(1'($urandom_range(1)), random_tag()));
         else
            send_and_gap(remove_word(wanted_type'($urandom_range(3))));
      end
   endtask

   // mode 0 all dogs, 1 all cats, 2 mixed classes
   task automatic fill_run();
      int   mode;
      int   extra;
      logic cls;
      mode = $urandom_range(2);
      while (store.held_count < CSF_DEPTH) begin
         cls = (mode == 2) ? 1'($urandom_range(1)) : 1'(mode);
         send_and_gap(append_word(cls, random_tag()));
      end
      extra = $urandom_range(1, 3);
      repeat (extra) send_and_gap(append_word(1'($urandom_range(1)), random_tag()));
      // full single-class store, ask for the other class: longest failed scan
      if (mode != 2) send_and_gap(remove_word((mode == 0) ? WANT_CAT : WANT_DOG));
   endtask

   task automatic drain_run();
      int extra;
      while (store.held_count > 0)
         send_and_gap(remove_word(wanted_type'($urandom_range(3))));
      extra = $urandom_range(1, 2);
      repeat (extra) send_and_gap(remove_word(wanted_type'($urandom_range(3))));
   endtask

   task automatic directed_run();
      tx_calm = 1'b0;
      send_and_gap(remove_word(WANT_ANY));
      send_and_gap(remove_word(WANT_DOG));
      send_and_gap(remove_word(WANT_CAT));
      send_and_gap(remove_word(WANT_UNUSED));
      send_and_gap(append_word(CLS_DOG, 16'h0000));
      send_and_gap(append_word(CLS_CAT, 16'hFFFF));
      send_and_gap(append_word(CLS_DOG, 16'h5555));
      send_and_gap(append_word(CLS_CAT, 16'hAAAA));
      send_and_gap(remove_word(WANT_CAT));      // hit in the middle
      send_and_gap(remove_word(WANT_UNUSED));   // takes the head
      send_and_gap(remove_word(WANT_DOG));
      send_and_gap(remove_word(WANT_DOG));      // only a cat left
      send_and_gap(remove_word(WANT_ANY));
      send_and_gap(append_word(CLS_CAT, 16'h1234));
      send_and_gap(append_word(CLS_CAT, 16'h8001));
      send_and_gap(remove_word(WANT_DOG));      // nonempty, no dog
      send_and_gap(append_word(CLS_DOG, 16'h7FFE));
      send_and_gap(remove_word(WANT_DOG));      // hit at the tail
      send_and_gap(remove_word(WANT_CAT));
      send_and_gap(remove_word(WANT_UNUSED));
   endtask

   task automatic random_run();
      int  start;
      int  kind;
      bit  paused_mid;
      start      = sent;
      paused_mid = 1'b0;
      // receiver holds off while items keep coming, so the block backs up
      tx_calm      = 1'b1;
      hold_off_req = 1'b1;
      mixed_run(24);
      fill_run();
      while (sent - start < RANDOM_ITEMS) begin
         if (!paused_mid && sent - start > RANDOM_ITEMS / 2) begin
            wait_drained();
            paused_mid = 1'b1;
         end
         tx_calm = ($urandom_range(4) == 0);
         kind    = $urandom_range(9);
         if (kind < 5)      mixed_run($urandom_range(8, 30));
         else if (kind < 7) fill_run();
         else               drain_run();
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_APPEND;
      req_bus.entry_class <= CLS_DOG;
      req_bus.entry_tag   <= '0;
      req_bus.wanted      <= WANT_ANY;
      sent         = 0;
      hold_off_req = 1'b0;
      tx_calm      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      directed_run();
      wait_drained();
      random_run();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("summary: %0d requests, %0d added, %0d removed, %0d on empty, %0d no match",
               sent, store.status_hits[ST_ADDED], store.status_hits[ST_REMOVED],
               store.status_hits[ST_EMPTY], store.status_hits[ST_NOMATCH]);
      $display("summary: %0d appends refused when full, peak fill %0d, %0d long receiver holds",
               store.status_hits[ST_FULL], store.peak_fill, holds_done);
      if (store.mismatches == 0 && store.due_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // result side: check accepted words, then pick next cycle's ready
   initial begin
      result_word_type got;
      int              hold_left;
      int              stall_left;
      int              cyc;
      hold_left  = 0;
      stall_left = 0;
      cyc        = 0;
      received   = 0;
      holds_done = 0;
      rx_calm    = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.tag    = rsp_bus.out_tag;
            got.cls    = rsp_bus.out_class;
            got.fill   = rsp_bus.fill;
            store.check_result(got);
            received++;
         end
         cyc++;
         if (cyc % 150 == 0) rx_calm = ($urandom_range(3) == 0);
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
            holds_done++;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!rx_calm) begin
            stall_left = pick_gap();
         end
         rsp_bus.ready <= (hold_left == 0 && stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* sim.f */
design/csf_pkg.sv
design/csf_if.sv
design/class_selective_fifo.sv
design/csf_checker.sv
sim/tb_top.sv
